[hdl/mdsc_pkg.sv]
// ============================================================================
// mdsc_pkg
// Shared types, codes and constants of the motor drive safety controller.
// ============================================================================
`default_nettype none

package mdsc_pkg;

    // item kinds
    localparam logic [1:0] MODE_APPLY = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // stop causes
    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_WATCHDOG = 2'd1;
    localparam logic [1:0] CAUSE_PULSE    = 2'd2;
    localparam logic [1:0] CAUSE_STALL    = 2'd3;

    // register map (index = paddr / 4)
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [2:0] REG_DRIVER_ATTACHED    = 3'd0;
    localparam logic [2:0] REG_ENABLE_PWM_MODE    = 3'd1;
    localparam logic [2:0] REG_ENCODERS_PRESENT   = 3'd2;
    localparam logic [2:0] REG_WATCHDOG_MS        = 3'd3;
    localparam logic [2:0] REG_STALL_LIMIT        = 3'd4;
    localparam logic [2:0] REG_STALL_FLOOR        = 3'd5;
    localparam logic [2:0] REG_PULSE_MAX_SPEED    = 3'd6;
    localparam logic [2:0] REG_PULSE_MAX_DUR_MS   = 3'd7;

    // register reset values
    localparam logic [15:0] WATCHDOG_MS_RST      = 16'd500;
    localparam logic [15:0] STALL_THRESHOLD_RST  = 16'd200;
    localparam logic [7:0]  STALL_FLOOR_RST      = 8'd10;
    localparam logic [6:0]  PULSE_MAX_SPEED_RST  = 7'd40;
    localparam logic [15:0] PULSE_MAX_DUR_RST    = 16'd2000;

    // drive math
    localparam logic [7:0]  SPEED_LIMIT   = 8'd100;
    // 10445/4096 overshoots 255/100 by < 0.005 over 0..100, so the floor is exact
    localparam logic [13:0] DUTY_RECIP    = 14'd10445;
    localparam logic [15:0] PULSE_MIN_MS  = 16'd50;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    localparam int unsigned STALL_CHECK_PERIOD_DEF = 50;

    typedef struct packed {
        logic        driver_attached;
        logic        enable_pwm_mode;
        logic        encoders_present;
        logic [15:0] watchdog_ms;
        logic [15:0] stall_limit_ticks;
        logic [7:0]  stall_speed_floor;
        logic [6:0]  pulse_max_speed;
        logic [15:0] pulse_max_duration_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [7:0]  left_speed;
        logic signed [7:0]  right_speed;
        logic [15:0]        duration_ms;
        logic [31:0]        left_encoder;
        logic [31:0]        right_encoder;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         pwm_ch0;
        logic [7:0]         pwm_ch1;
        logic [7:0]         pwm_ch2;
        logic [7:0]         pwm_ch3;
        logic               left_fwd_level;
        logic               left_bwd_level;
        logic               right_fwd_level;
        logic               right_bwd_level;
        logic signed [7:0]  left_speed_now;
        logic signed [7:0]  right_speed_now;
        logic [1:0]         stop_cause;
        logic               speed_changed;
    } res_t;

    // timer status seen by the top level
    typedef struct packed {
        logic wd_armed;
        logic pulse_armed;
        logic stall_armed;
        logic held_nonzero;
    } stat_t;

endpackage

`default_nettype wire

[hdl/mdsc_if.sv]
// ============================================================================
// mdsc_if
// Valid/ready channels for command words and result words.
// ============================================================================
`default_nettype none

interface mdsc_cmd_if;
    import mdsc_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mdsc_res_if;
    import mdsc_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/mdsc_apb_regs.sv]
// ============================================================================
// mdsc_apb_regs
// APB register file holding the controller configuration.
// ============================================================================
`default_nettype none

module mdsc_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mdsc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mdsc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [mdsc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready,
    output      mdsc_pkg::cfg_t                  cfg
);
    import mdsc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DRIVER_ATTACHED:    cfg_next.driver_attached       = pwdata[0];
                REG_ENABLE_PWM_MODE:    cfg_next.enable_pwm_mode       = pwdata[0];
                REG_ENCODERS_PRESENT:   cfg_next.encoders_present      = pwdata[0];
                REG_WATCHDOG_MS:        cfg_next.watchdog_ms           = pwdata[15:0];
                REG_STALL_LIMIT:        cfg_next.stall_limit_ticks     = pwdata[15:0];
                REG_STALL_FLOOR:        cfg_next.stall_speed_floor     = pwdata[7:0];
                REG_PULSE_MAX_SPEED:    cfg_next.pulse_max_speed       = pwdata[6:0];
                REG_PULSE_MAX_DUR_MS:   cfg_next.pulse_max_duration_ms = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.driver_attached       <= 1'b0;
            cfg_reg.enable_pwm_mode       <= 1'b0;
            cfg_reg.encoders_present      <= 1'b0;
            cfg_reg.watchdog_ms           <= WATCHDOG_MS_RST;
            cfg_reg.stall_limit_ticks     <= STALL_THRESHOLD_RST;
            cfg_reg.stall_speed_floor     <= STALL_FLOOR_RST;
            cfg_reg.pulse_max_speed       <= PULSE_MAX_SPEED_RST;
            cfg_reg.pulse_max_duration_ms <= PULSE_MAX_DUR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DRIVER_ATTACHED:    prdata = {31'd0, cfg_reg.driver_attached};
            REG_ENABLE_PWM_MODE:    prdata = {31'd0, cfg_reg.enable_pwm_mode};
            REG_ENCODERS_PRESENT:   prdata = {31'd0, cfg_reg.encoders_present};
            REG_WATCHDOG_MS:        prdata = {16'd0, cfg_reg.watchdog_ms};
            REG_STALL_LIMIT:        prdata = {16'd0, cfg_reg.stall_limit_ticks};
            REG_STALL_FLOOR:        prdata = {24'd0, cfg_reg.stall_speed_floor};
            REG_PULSE_MAX_SPEED:    prdata = {25'd0, cfg_reg.pulse_max_speed};
            REG_PULSE_MAX_DUR_MS:   prdata = {16'd0, cfg_reg.pulse_max_duration_ms};
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/mdsc_core.sv]
// ============================================================================
// mdsc_core
// Speed, drive and timer state with the per-word update logic.
// ============================================================================
`default_nettype none

module mdsc_core #(
    parameter int unsigned STALL_CHECK_PERIOD = mdsc_pkg::STALL_CHECK_PERIOD_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire mdsc_pkg::cmd_t item,
    input  wire mdsc_pkg::cfg_t cfg,
    output      mdsc_pkg::res_t result,
    output      mdsc_pkg::stat_t status
);
    import mdsc_pkg::*;

    localparam int unsigned PW = $clog2(STALL_CHECK_PERIOD + 1);

    typedef struct packed {
        logic [3:0][7:0] duty;
        logic [3:0]      levels;
    } drive_t;

    typedef struct packed {
        logic signed [7:0] held_l;
        logic signed [7:0] held_r;
        drive_t            drive;
        logic [15:0]       wd_rem;
        logic              wd_armed;
        logic [15:0]       pulse_rem;
        logic              pulse_armed;
        logic              stall_armed;
        logic [1:0][31:0]  base;
        logic [1:0][15:0]  elapsed;
    } st_t;

    st_t           st_reg;
    st_t           st_next;
    logic [PW-1:0] period_reg;
    logic [PW-1:0] period_next;
    logic [1:0]    cause;
    logic          changed;
    logic          hit;
    logic signed [7:0] cmd_l;
    logic signed [7:0] cmd_r;
    logic [15:0]   dur;
    logic signed [7:0] side_speed;
    logic [31:0]   side_enc;

    // |s|, with -128 giving 128
    function automatic logic [7:0] mag8(input logic signed [7:0] s);
        logic [7:0] u;
        u = s;
        return s[7] ? (8'd0 - u) : u;
    endfunction

    // min(|s|,100)*255/100
    function automatic logic [7:0] duty_of(input logic signed [7:0] s);
        logic [7:0]  m;
        logic [21:0] p;
        m = mag8(s);
        if (m > SPEED_LIMIT)
            m = SPEED_LIMIT;
        p = 22'(m) * 22'(DUTY_RECIP);
        return p[19:12];
    endfunction

    function automatic logic signed [7:0] clamp_speed(input logic signed [7:0] s,
                                                       input logic [6:0] lim);
        logic signed [8:0] s9;
        logic signed [8:0] l9;
        logic signed [8:0] r9;
        s9 = {s[7], s};
        l9 = {2'b00, lim};
        if (s9 < -l9)
            r9 = -l9;
        else if (s9 > l9)
            r9 = l9;
        else
            r9 = s9;
        return r9[7:0];
    endfunction

    // one side of the H-bridge outputs
    function automatic drive_t drive_side(input drive_t d, input logic side,
                                          input logic signed [7:0] s, input logic en_mode);
        drive_t     r;
        logic [7:0] duty;
        r    = d;
        duty = duty_of(s);
        if (en_mode)
        begin
            r.levels[{side, 1'b0}] = (s != 8'sd0) && !s[7];
            r.levels[{side, 1'b1}] = s[7];
            r.duty[{1'b0, side}]   = duty;
        end
        else
        begin
            r.duty[{side, 1'b0}] = s[7] ? 8'd0 : duty;
            r.duty[{side, 1'b1}] = s[7] ? duty : 8'd0;
        end
        return r;
    endfunction

    // set speeds and rearm watchdog/stall (period counter handled by caller)
    function automatic st_t apply(input st_t s, input logic signed [7:0] l,
                                  input logic signed [7:0] r, input logic [31:0] enc_l,
                                  input logic [31:0] enc_r, input cfg_t c);
        st_t n;
        n             = s;
        n.held_l      = l;
        n.held_r      = r;
        n.pulse_armed = 1'b0;
        if (c.driver_attached)
        begin
            n.drive = drive_side(n.drive, 1'b0, l, c.enable_pwm_mode);
            n.drive = drive_side(n.drive, 1'b1, r, c.enable_pwm_mode);
        end
        n.wd_armed    = 1'b0;
        n.stall_armed = 1'b0;
        if (l != 8'sd0 || r != 8'sd0)
        begin
            n.wd_armed = 1'b1;
            n.wd_rem   = c.watchdog_ms;
            if (c.encoders_present)
            begin
                n.base[0]     = enc_l;
                n.base[1]     = enc_r;
                n.elapsed[0]  = '0;
                n.elapsed[1]  = '0;
                n.stall_armed = 1'b1;
            end
        end
        return n;
    endfunction

    // next state for the word in the input register
    always_comb
    begin
        st_next     = st_reg;
        period_next = period_reg;
        cause       = CAUSE_NONE;
        changed     = 1'b0;
        hit         = 1'b0;
        side_speed  = '0;
        side_enc    = '0;
        cmd_l       = item.left_speed;
        cmd_r       = item.right_speed;
        dur         = item.duration_ms;
        if (step)
        begin
            case (item.mode)
                MODE_APPLY, MODE_PULSE:
                begin
                    if (item.mode == MODE_PULSE)
                    begin
                        cmd_l = clamp_speed(item.left_speed, cfg.pulse_max_speed);
                        cmd_r = clamp_speed(item.right_speed, cfg.pulse_max_speed);
                        if (dur < PULSE_MIN_MS)
                            dur = PULSE_MIN_MS;
                        if (dur > cfg.pulse_max_duration_ms)
                            dur = cfg.pulse_max_duration_ms;
                    end
                    st_next = apply(st_next, cmd_l, cmd_r, item.left_encoder,
                                    item.right_encoder, cfg);
                    if ((cmd_l != 8'sd0 || cmd_r != 8'sd0) && cfg.encoders_present)
                        period_next = '0;
                    if (item.mode == MODE_PULSE)
                    begin
                        st_next.pulse_armed = 1'b1;
                        st_next.pulse_rem   = dur;
                    end
                    changed = 1'b1;
                end
                MODE_TICK:
                begin
                    // watchdog
                    if (st_next.wd_armed)
                    begin
                        if (st_next.wd_rem <= 16'd1)
                        begin
                            st_next.wd_rem   = '0;
                            st_next.wd_armed = 1'b0;
                            if (st_next.held_l != 8'sd0 || st_next.held_r != 8'sd0)
                            begin
                                st_next = apply(st_next, 8'sd0, 8'sd0, item.left_encoder,
                                                item.right_encoder, cfg);
                                cause   = CAUSE_WATCHDOG;
                                changed = 1'b1;
                            end
                        end
                        else
                        begin
                            st_next.wd_rem = st_next.wd_rem - 16'd1;
                        end
                    end
                    // pulse end
                    if (st_next.pulse_armed)
                    begin
                        if (st_next.pulse_rem <= 16'd1)
                        begin
                            st_next.pulse_rem   = '0;
                            st_next.pulse_armed = 1'b0;
                            st_next.held_l      = '0;
                            st_next.held_r      = '0;
                            if (cfg.driver_attached)
                            begin
                                st_next.drive = drive_side(st_next.drive, 1'b0, 8'sd0,
                                                           cfg.enable_pwm_mode);
                                st_next.drive = drive_side(st_next.drive, 1'b1, 8'sd0,
                                                           cfg.enable_pwm_mode);
                            end
                            st_next.stall_armed = 1'b0;
                            cause   = CAUSE_PULSE;
                            changed = 1'b1;
                        end
                        else
                        begin
                            st_next.pulse_rem = st_next.pulse_rem - 16'd1;
                        end
                    end
                    // stall check
                    if (st_next.stall_armed)
                    begin
                        for (int k = 0; k < 2; k++)
                        begin
                            if (st_next.elapsed[k] < ELAPSED_MAX)
                                st_next.elapsed[k] = st_next.elapsed[k] + 16'd1;
                        end
                        period_next = period_next + PW'(1);
                        if (period_next >= PW'(STALL_CHECK_PERIOD))
                        begin
                            period_next = '0;
                            if (cfg.encoders_present)
                            begin
                                for (int k = 0; k < 2; k++)
                                begin
                                    side_speed = (k == 0) ? st_next.held_l : st_next.held_r;
                                    side_enc   = (k == 0) ? item.left_encoder
                                                          : item.right_encoder;
                                    if (mag8(side_speed) >= cfg.stall_speed_floor)
                                    begin
                                        if (side_enc != st_next.base[k])
                                        begin
                                            st_next.base[k]    = side_enc;
                                            st_next.elapsed[k] = '0;
                                        end
                                        else if (st_next.elapsed[k] > cfg.stall_limit_ticks)
                                        begin
                                            hit = 1'b1;
                                        end
                                    end
                                end
                                if (hit)
                                begin
                                    st_next = apply(st_next, 8'sd0, 8'sd0, item.left_encoder,
                                                    item.right_encoder, cfg);
                                    cause   = CAUSE_STALL;
                                    changed = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result word from the updated state
    always_comb
    begin
        result.pwm_ch0         = st_next.drive.duty[0];
        result.pwm_ch1         = st_next.drive.duty[1];
        result.pwm_ch2         = cfg.enable_pwm_mode ? 8'd0 : st_next.drive.duty[2];
        result.pwm_ch3         = cfg.enable_pwm_mode ? 8'd0 : st_next.drive.duty[3];
        result.left_fwd_level  = cfg.enable_pwm_mode && st_next.drive.levels[0];
        result.left_bwd_level  = cfg.enable_pwm_mode && st_next.drive.levels[1];
        result.right_fwd_level = cfg.enable_pwm_mode && st_next.drive.levels[2];
        result.right_bwd_level = cfg.enable_pwm_mode && st_next.drive.levels[3];
        result.left_speed_now  = st_next.held_l;
        result.right_speed_now = st_next.held_r;
        result.stop_cause      = cause;
        result.speed_changed   = changed;
    end

    assign status.wd_armed     = st_reg.wd_armed;
    assign status.pulse_armed  = st_reg.pulse_armed;
    assign status.stall_armed  = st_reg.stall_armed;
    assign status.held_nonzero = (st_reg.held_l != 8'sd0) || (st_reg.held_r != 8'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= '0;
            period_reg <= '0;
        end
        else if (step)
        begin
            st_reg     <= st_next;
            period_reg <= period_next;
        end
    end

endmodule

`default_nettype wire

[hdl/motor_drive_safety_controller_top.sv]
// ============================================================================
// motor_drive_safety_controller_top: two-motor drive with watchdog/pulse/stall stops
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the result slot is free or being drained.
// Reset: rst_n async low; speeds, drive, timers cleared, registers to defaults.
// ============================================================================
`default_nettype none

module motor_drive_safety_controller_top #(
    parameter int unsigned STALL_CHECK_PERIOD = mdsc_pkg::STALL_CHECK_PERIOD_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mdsc_cmd_if.sink                             cmd,
    mdsc_res_if.source                           res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mdsc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mdsc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [mdsc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready
);
    import mdsc_pkg::*;

    cfg_t  cfg;
    res_t  core_res;
    stat_t status;

    logic  in_valid_reg;
    logic  in_valid_next;
    cmd_t  in_item_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_data_reg;
    logic  advance;
    logic  step;

    mdsc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdsc_core #(
        .STALL_CHECK_PERIOD (STALL_CHECK_PERIOD)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_res),
        .status (status)
    );

    // pipeline control: result slot free or being drained
    assign advance   = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd.ready)
            in_valid_next = cmd.valid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_item_reg <= cmd.data;
        if (step)
            out_data_reg <= core_res;
    end

    // a stop always reports zero speeds as a change
    a_stop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.data.stop_cause != CAUSE_NONE) |->
            res.data.speed_changed && (res.data.left_speed_now == 8'sd0)
            && (res.data.right_speed_now == 8'sd0))
        else $error("stop reported without zeroed speeds");

    // stall check only runs under a live watchdog
    a_stall_needs_wd: assert property (@(posedge clk) disable iff (!rst_n)
        status.stall_armed |-> status.wd_armed)
        else $error("stall check armed without watchdog");

    // nonzero held speed is always guarded by the watchdog
    a_moving_needs_wd: assert property (@(posedge clk) disable iff (!rst_n)
        status.held_nonzero |-> status.wd_armed)
        else $error("motors running without watchdog");

    // full pipeline with a stalled result must not take a new word
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !res.ready |-> !cmd.ready)
        else $error("input accepted while pipeline is full");

endmodule

`default_nettype wire
